// ----- rtl/fvsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fvsd_pkg
// Shared types, constants and table functions for the FOC voltage to SVPWM
// duty pipeline.
// ----------------------------------------------------------------------------
package fvsd_pkg;

  localparam int ANGLE_BITS       = 14;
  localparam int TRIG_TABLE_DEPTH = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [6:0]  POLE_MULT_RST   = 7'd11;
  localparam logic [15:0] ZERO_OFFSET_RST = 16'd0;
  localparam logic [15:0] PWM_PERIOD_RST  = 16'd4199;
  localparam logic [15:0] BUS_RECIP_RST   = 16'd1398;

  localparam logic [63:0]        HALFPI_Q30   = 64'd1686629713;
  localparam logic signed [15:0] SQRT3_Q14    = 16'sd28378;
  localparam logic [14:0]        QUARTER_TURN = 15'd16384;
  localparam logic [2:0]         NUM_SECTORS  = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_MULT   = 2'd0,
    CFG_ZERO_OFFSET = 2'd1,
    CFG_PWM_PERIOD  = 2'd2,
    CFG_BUS_RECIP   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]  pole_mult;
    logic [15:0] zero_offset;
    logic [15:0] pwm_period;
    logic [15:0] bus_recip;
  } cfg_t;

  typedef struct packed {
    logic [15:0] elec;
    logic [2:0]  sector;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [47:0] pa;
    logic signed [47:0] pb;
    logic signed [47:0] pc;
  } phase_t;

  typedef struct packed {
    tag_t        tag;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
  } res_t;

  // Q15 sine of r * (pi/2) / 16384 by a Taylor series; elaboration use only.
  function automatic logic signed [15:0] quarter_sine(input logic [14:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(r) * HALFPI_Q30) >> 14;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        default: term = term / 64'd110;
      endcase
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return 16'(sum);
  endfunction

  // Sine of u / 65536 turns, Q15, folded onto the first quadrant.
  function automatic logic signed [15:0] sine_of_turn(input logic [15:0] u);
    logic [1:0]         q;
    logic [14:0]        r;
    logic signed [15:0] v;
    q = u[15:14];
    r = {1'b0, u[13:0]};
    if (q[0]) begin
      r = QUARTER_TURN - r;
    end
    v = quarter_sine(r);
    return q[1] ? -v : v;
  endfunction

endpackage

// ----- rtl/fvsd_in_if.sv -----
// ----------------------------------------------------------------------------
// fvsd_in_if
// Input channel: rotor angle and d/q voltage command with valid/ready.
// ----------------------------------------------------------------------------
interface fvsd_in_if #(
  parameter int AngleBits = fvsd_pkg::ANGLE_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [AngleBits-1:0] mech_angle;
  logic signed [15:0]   volt_d;
  logic signed [15:0]   volt_q;

  modport source (output valid, mech_angle, volt_d, volt_q, input ready);
  modport sink   (input valid, mech_angle, volt_d, volt_q, output ready);
endinterface

// ----- rtl/fvsd_out_if.sv -----
// ----------------------------------------------------------------------------
// fvsd_out_if
// Output channel: three phase compare counts, sector and electrical angle.
// ----------------------------------------------------------------------------
interface fvsd_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
  logic [2:0]  sector_index;
  logic [15:0] elec_angle;

  modport source (output valid, duty_a, duty_b, duty_c, sector_index, elec_angle,
                  input ready);
  modport sink   (input valid, duty_a, duty_b, duty_c, sector_index, elec_angle,
                  output ready);
endinterface

// ----- rtl/fvsd_angle.sv -----
// ----------------------------------------------------------------------------
// fvsd_angle
// Two stages: electrical angle from the mechanical angle, then sector and
// sine/cosine table lookup.
// ----------------------------------------------------------------------------
module fvsd_angle #(
  parameter int TrigDepth = fvsd_pkg::TRIG_TABLE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fvsd_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fvsd_pkg::ANGLE_BITS-1:0]    mech_angle_i,
  input  logic signed [15:0]                 volt_d_i,
  input  logic signed [15:0]                 volt_q_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fvsd_pkg::trig_t                    out_o
);

  localparam int AngleBits = fvsd_pkg::ANGLE_BITS;
  localparam int IdxBits   = $clog2(TrigDepth);
  localparam int ProdW     = IdxBits + 17;

  logic signed [15:0] sin_rom [TrigDepth];
  logic signed [15:0] cos_rom [TrigDepth];

  for (genvar k = 0; k < TrigDepth; k++) begin : g_rom
    assign sin_rom[k] = fvsd_pkg::sine_of_turn(16'((k * 65536) / TrigDepth));
    assign cos_rom[k] = fvsd_pkg::sine_of_turn(16'((k * 65536) / TrigDepth + 16384));
  end

  logic               v0_q, v1_q;
  logic               rdy0, rdy1;
  logic [15:0]        elec_q, elec_d;
  logic signed [15:0] vd0_q, vq0_q;
  fvsd_pkg::trig_t    out_q, out_d;

  logic [AngleBits+6:0] pm;
  logic [22:0]          pm_wide;
  logic [ProdW-1:0]     idx_prod;
  logic [IdxBits-1:0]   idx;
  logic [18:0]          sec_prod;

  assign rdy1       = !v1_q || out_ready_i;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  always_comb begin
    pm      = (AngleBits + 7)'(cfg_i.pole_mult) * (AngleBits + 7)'(mech_angle_i);
    pm_wide = 23'(pm) << (16 - AngleBits);
    elec_d  = pm_wide[15:0] + cfg_i.zero_offset;
  end

  always_comb begin
    idx_prod = ProdW'(elec_q) * ProdW'(TrigDepth);
    idx      = idx_prod[16 +: IdxBits];
    sec_prod = 19'(elec_q) * 19'(fvsd_pkg::NUM_SECTORS);
    out_d.tag.elec   = elec_q;
    out_d.tag.sector = sec_prod[18:16];
    out_d.volt_d     = vd0_q;
    out_d.volt_q     = vq0_q;
    out_d.sin_v      = sin_rom[idx];
    out_d.cos_v      = cos_rom[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      elec_q <= elec_d;
      vd0_q  <= volt_d_i;
      vq0_q  <= volt_q_i;
    end
    if (rdy1 && v0_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v1_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/fvsd_xform.sv -----
// ----------------------------------------------------------------------------
// fvsd_xform
// Four stages: inverse Park products, alpha/beta sums, sqrt(3) scaling and
// inverse Clarke phase voltages (mV * 2^30).
// ----------------------------------------------------------------------------
module fvsd_xform (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fvsd_pkg::trig_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fvsd_pkg::phase_t out_o
);

  localparam int NumStages = 4;

  logic [NumStages-1:0] v_q, rdy, prev, en;

  fvsd_pkg::tag_t     tag_q [NumStages];
  logic signed [31:0] dc0_q, qs0_q, ds0_q, qc0_q;
  logic signed [32:0] alpha1_q, beta1_q;
  logic signed [32:0] alpha2_q;
  logic signed [47:0] bk2_q;
  logic signed [47:0] pa3_q, pb3_q, pc3_q;
  logic signed [47:0] ah;

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign prev       = {v_q[NumStages-2:0], in_valid_i};
  assign en         = rdy & prev;
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) v_q[k] <= prev[k];
      end
    end
  end

  assign ah = 48'(alpha2_q) <<< 14;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tag_q[0] <= in_i.tag;
      dc0_q    <= signed'(in_i.volt_d) * signed'(in_i.cos_v);
      qs0_q    <= signed'(in_i.volt_q) * signed'(in_i.sin_v);
      ds0_q    <= signed'(in_i.volt_d) * signed'(in_i.sin_v);
      qc0_q    <= signed'(in_i.volt_q) * signed'(in_i.cos_v);
    end
    if (en[1]) begin
      tag_q[1] <= tag_q[0];
      alpha1_q <= 33'(dc0_q) - 33'(qs0_q);
      beta1_q  <= 33'(ds0_q) + 33'(qc0_q);
    end
    if (en[2]) begin
      tag_q[2] <= tag_q[1];
      alpha2_q <= alpha1_q;
      bk2_q    <= 48'(beta1_q) * 48'(fvsd_pkg::SQRT3_Q14);
    end
    if (en[3]) begin
      tag_q[3] <= tag_q[2];
      pa3_q    <= 48'(alpha2_q) <<< 15;
      pb3_q    <= bk2_q - ah;
      pc3_q    <= 48'sd0 - ah - bk2_q;
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign out_o.tag   = tag_q[NumStages-1];
  assign out_o.pa    = pa3_q;
  assign out_o.pb    = pb3_q;
  assign out_o.pc    = pc3_q;

endmodule

// ----- rtl/fvsd_svpwm.sv -----
// ----------------------------------------------------------------------------
// fvsd_svpwm
// Four stages: min/max midpoint, split bus-reciprocal multiply, rounding and
// duty fraction clamp, period scaling into the output register.
// ----------------------------------------------------------------------------
module fvsd_svpwm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fvsd_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fvsd_pkg::phase_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fvsd_pkg::res_t   out_o
);

  localparam int NumStages = 4;
  localparam int NumPhases = 3;

  localparam logic signed [66:0] RoundHalf = 67'sd1 <<< 30;
  localparam logic signed [36:0] DutyHalf  = 37'sd1 <<< 23;
  localparam logic signed [36:0] DutyFull  = 37'sd1 <<< 24;

  logic [NumStages-1:0] v_q, rdy, prev, en;

  fvsd_pkg::tag_t     tag_q [NumStages];
  logic signed [47:0] p_in  [NumPhases];
  logic signed [47:0] p1_q  [NumPhases];
  logic signed [47:0] mx, mn;
  logic signed [48:0] sum1_q;
  logic signed [49:0] d     [NumPhases];
  logic [40:0]        mlo2_q [NumPhases];
  logic signed [41:0] mhi2_q [NumPhases];
  logic signed [66:0] m     [NumPhases];
  logic signed [35:0] r     [NumPhases];
  logic signed [36:0] ts    [NumPhases];
  logic [24:0]        t_d   [NumPhases];
  logic [24:0]        t3_q  [NumPhases];
  logic [40:0]        prod  [NumPhases];
  logic [15:0]        duty_q [NumPhases];

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign prev       = {v_q[NumStages-2:0], in_valid_i};
  assign en         = rdy & prev;
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) v_q[k] <= prev[k];
      end
    end
  end

  assign p_in[0] = in_i.pa;
  assign p_in[1] = in_i.pb;
  assign p_in[2] = in_i.pc;

  always_comb begin
    mx = p_in[0];
    mn = p_in[0];
    for (int i = 1; i < NumPhases; i++) begin
      if (p_in[i] > mx) mx = p_in[i];
      if (p_in[i] < mn) mn = p_in[i];
    end
  end

  // d = 2 * (U - mid), split in two halves so each multiply stays narrow
  always_comb begin
    for (int i = 0; i < NumPhases; i++) begin
      d[i] = (50'(p1_q[i]) <<< 1) - 50'(sum1_q);
    end
  end

  // Round to Q24 and clamp the duty fraction to 0..1 before scaling by period
  always_comb begin
    for (int i = 0; i < NumPhases; i++) begin
      m[i]  = (67'(mhi2_q[i]) <<< 25) + 67'(mlo2_q[i]) + RoundHalf;
      r[i]  = 36'(m[i] >>> 31);
      ts[i] = 37'(r[i]) + DutyHalf;
      if (ts[i] < 0) begin
        t_d[i] = '0;
      end else if (ts[i] > DutyFull) begin
        t_d[i] = 25'(DutyFull);
      end else begin
        t_d[i] = 25'(ts[i]);
      end
      prod[i] = 41'(cfg_i.pwm_period) * 41'(t3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tag_q[0] <= in_i.tag;
      sum1_q   <= 49'(mx) + 49'(mn);
      for (int i = 0; i < NumPhases; i++) p1_q[i] <= p_in[i];
    end
    if (en[1]) begin
      tag_q[1] <= tag_q[0];
      for (int i = 0; i < NumPhases; i++) begin
        mlo2_q[i] <= 41'(d[i][24:0]) * 41'(cfg_i.bus_recip);
        mhi2_q[i] <= 42'(signed'(d[i][49:25])) * 42'(signed'({1'b0, cfg_i.bus_recip}));
      end
    end
    if (en[2]) begin
      tag_q[2] <= tag_q[1];
      for (int i = 0; i < NumPhases; i++) t3_q[i] <= t_d[i];
    end
    if (en[3]) begin
      tag_q[3] <= tag_q[2];
      for (int i = 0; i < NumPhases; i++) duty_q[i] <= prod[i][39:24];
    end
  end

  assign out_valid_o  = v_q[NumStages-1];
  assign out_o.tag    = tag_q[NumStages-1];
  assign out_o.duty_a = duty_q[0];
  assign out_o.duty_b = duty_q[1];
  assign out_o.duty_c = duty_q[2];

endmodule

// ----- rtl/foc_voltage_to_svpwm_duty_top.sv -----
// ----------------------------------------------------------------------------
// foc_voltage_to_svpwm_duty_top
// Electrical angle, inverse Park/Clarke and centered SVPWM duty generation.
// ----------------------------------------------------------------------------
//  port     dir  handshake          beat contents
//  in_i     in   valid/ready        mech_angle, volt_d, volt_q
//  out_o    out  valid/ready        duty_a/b/c, sector_index, elec_angle
//  cfg_*    in   cfg_we_i only      cfg_idx_i selects register, cfg_data_i
//
// One beat per cycle sustained while out_o accepts beats; the register
// pipeline holds 2 angle/table, 4 Park/Clarke and 4 SVPWM stages.
// Reset clears every stage valid bit and loads the register defaults.
// A stalled out_o holds its beat; upstream stages keep filling bubbles and
// in_i.ready drops only when every stage holds a beat.
// ----------------------------------------------------------------------------
module foc_voltage_to_svpwm_duty_top #(
  parameter int TrigTableDepth = fvsd_pkg::TRIG_TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fvsd_in_if.sink                           in_i,
  fvsd_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [fvsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fvsd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  fvsd_pkg::cfg_t   cfg_q;
  fvsd_pkg::trig_t  trig;
  fvsd_pkg::phase_t phase;
  fvsd_pkg::res_t   res;
  logic             trig_valid, trig_ready;
  logic             phase_valid, phase_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pole_mult   <= fvsd_pkg::POLE_MULT_RST;
      cfg_q.zero_offset <= fvsd_pkg::ZERO_OFFSET_RST;
      cfg_q.pwm_period  <= fvsd_pkg::PWM_PERIOD_RST;
      cfg_q.bus_recip   <= fvsd_pkg::BUS_RECIP_RST;
    end else if (cfg_we_i) begin
      unique case (fvsd_pkg::cfg_idx_e'(cfg_idx_i))
        fvsd_pkg::CFG_POLE_MULT:   cfg_q.pole_mult   <= cfg_data_i[6:0];
        fvsd_pkg::CFG_ZERO_OFFSET: cfg_q.zero_offset <= cfg_data_i;
        fvsd_pkg::CFG_PWM_PERIOD:  cfg_q.pwm_period  <= cfg_data_i;
        fvsd_pkg::CFG_BUS_RECIP:   cfg_q.bus_recip   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fvsd_angle #(
    .TrigDepth (TrigTableDepth)
  ) u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .mech_angle_i (in_i.mech_angle),
    .volt_d_i     (in_i.volt_d),
    .volt_q_i     (in_i.volt_q),
    .out_valid_o  (trig_valid),
    .out_ready_i  (trig_ready),
    .out_o        (trig)
  );

  fvsd_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (trig_valid),
    .in_ready_o  (trig_ready),
    .in_i        (trig),
    .out_valid_o (phase_valid),
    .out_ready_i (phase_ready),
    .out_o       (phase)
  );

  fvsd_svpwm u_svpwm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (phase_valid),
    .in_ready_o  (phase_ready),
    .in_i        (phase),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.duty_a       = res.duty_a;
  assign out_o.duty_b       = res.duty_b;
  assign out_o.duty_c       = res.duty_c;
  assign out_o.sector_index = res.tag.sector;
  assign out_o.elec_angle   = res.tag.elec;

endmodule
